/* rtl/core/bsm_pkg.sv */
// Shared types, microcode and saturating arithmetic for the Brent minimizer.
package bsm_pkg;

    localparam int VAL_W  = 48;
    localparam int WIDE_W = 64;
    localparam int ITER_W = 10;
    localparam int REL_W  = 32;
    localparam int PC_W   = 7;
    localparam int NUM_TMP = 14;

    localparam logic [WIDE_W-1:0] MAX64 = {1'b0, {(WIDE_W-1){1'b1}}};
    localparam logic [WIDE_W-1:0] MIN64 = {1'b1, {(WIDE_W-1){1'b0}}};
    localparam logic [63:0] GOLD_Q40 = 64'd419976070785;

    typedef enum logic [4:0] {
        OP_NOP, OP_MOV, OP_ADD, OP_SUB, OP_NEG, OP_ABS, OP_HALF, OP_SAT,
        OP_LT, OP_CSEL, OP_MUL, OP_TOL, OP_DIV, OP_COMMIT,
        OP_START, OP_LOADF, OP_UPDATE
    } op_t;

    // temporaries first (index = low four bits), then read-only sources
    typedef enum logic [4:0] {
        R_M, R_TOL, R_T2, R_HW, R_P, R_Q, R_R, R_D, R_E, R_U, R_S1, R_S2, R_XW, R_XV,
        S_ZERO, S_LO, S_HI, S_X, S_W, S_V, S_FX, S_FW, S_FV, S_STEP, S_PREV, S_GOLD
    } src_t;

    typedef enum logic [2:0] {J_NEXT, J_IF, J_IFN, J_GOTO, J_STOP, J_REQ} jmp_t;

    typedef enum logic [1:0] {K_REQ = 2'd0, K_DONE = 2'd1, K_REJ = 2'd2} kind_t;

    typedef enum logic [1:0] {PH_IDLE, PH_F0, PH_FU} phase_t;

    typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_WAIT, ST_EMIT} state_t;

    typedef struct packed {
        op_t       op;
        src_t      dst;
        src_t      sa;
        src_t      sb;
        jmp_t      jmp;
        logic [PC_W-1:0] tgt;
    } uc_t;

    typedef struct packed {
        logic exec;
        op_t  op;
        src_t dst;
        src_t sa;
        src_t sb;
    } dp_cmd_t;

    typedef struct packed {
        logic lt;
        logic unit_done;
        logic iter_done;
    } dp_stat_t;

    // branch targets
    localparam logic [PC_W-1:0] UA_PARTEST = 7'd35;
    localparam logic [PC_W-1:0] UA_FIXTOL  = 7'd53;
    localparam logic [PC_W-1:0] UA_GOLDEN  = 7'd56;
    localparam logic [PC_W-1:0] UA_FINAL   = 7'd62;
    localparam logic [PC_W-1:0] UA_USED    = 7'd68;
    localparam logic [PC_W-1:0] UA_COMMIT  = 7'd69;

    function automatic uc_t mk(op_t op, src_t dst, src_t sa, src_t sb, jmp_t j,
                               logic [PC_W-1:0] tgt);
        uc_t w;
        w.op = op; w.dst = dst; w.sa = sa; w.sb = sb; w.jmp = j; w.tgt = tgt;
        return w;
    endfunction

    function automatic uc_t uc_rom(logic [PC_W-1:0] pc);
        uc_t w;
        w = mk(OP_NOP, R_S1, S_ZERO, S_ZERO, J_NEXT, '0);
        case (pc)
            7'd0:  w = mk(OP_TOL,  R_TOL, S_X,   S_ZERO, J_NEXT, '0);
            7'd1:  w = mk(OP_ADD,  R_S1,  S_LO,  S_HI,   J_NEXT, '0);
            7'd2:  w = mk(OP_HALF, R_M,   R_S1,  S_ZERO, J_NEXT, '0);
            7'd3:  w = mk(OP_ADD,  R_T2,  R_TOL, R_TOL,  J_NEXT, '0);
            7'd4:  w = mk(OP_SUB,  R_S1,  S_HI,  S_LO,   J_NEXT, '0);
            7'd5:  w = mk(OP_HALF, R_HW,  R_S1,  S_ZERO, J_NEXT, '0);
            7'd6:  w = mk(OP_SUB,  R_S1,  S_X,   R_M,    J_NEXT, '0);
            7'd7:  w = mk(OP_ABS,  R_S1,  R_S1,  S_ZERO, J_NEXT, '0);
            7'd8:  w = mk(OP_SUB,  R_S2,  R_T2,  R_HW,   J_NEXT, '0);
            7'd9:  w = mk(OP_LT,   R_S1,  R_S2,  R_S1,   J_STOP, '0);
            7'd10: w = mk(OP_MOV,  R_P,   S_ZERO, S_ZERO, J_NEXT, '0);
            7'd11: w = mk(OP_MOV,  R_Q,   S_ZERO, S_ZERO, J_NEXT, '0);
            7'd12: w = mk(OP_MOV,  R_R,   S_ZERO, S_ZERO, J_NEXT, '0);
            7'd13: w = mk(OP_MOV,  R_D,   S_STEP, S_ZERO, J_NEXT, '0);
            7'd14: w = mk(OP_MOV,  R_E,   S_PREV, S_ZERO, J_NEXT, '0);
            7'd15: w = mk(OP_ABS,  R_S1,  R_E,   S_ZERO, J_NEXT, '0);
            7'd16: w = mk(OP_LT,   R_S1,  R_TOL, R_S1,   J_IFN, UA_PARTEST);
            7'd17: w = mk(OP_SUB,  R_XW,  S_X,   S_W,    J_NEXT, '0);
            7'd18: w = mk(OP_SUB,  R_XV,  S_X,   S_V,    J_NEXT, '0);
            7'd19: w = mk(OP_SUB,  R_S1,  S_FX,  S_FV,   J_NEXT, '0);
            7'd20: w = mk(OP_MUL,  R_R,   R_XW,  R_S1,   J_NEXT, '0);
            7'd21: w = mk(OP_SUB,  R_S1,  S_FX,  S_FW,   J_NEXT, '0);
            7'd22: w = mk(OP_MUL,  R_Q,   R_XV,  R_S1,   J_NEXT, '0);
            7'd23: w = mk(OP_MUL,  R_S1,  R_XV,  R_Q,    J_NEXT, '0);
            7'd24: w = mk(OP_MUL,  R_S2,  R_XW,  R_R,    J_NEXT, '0);
            7'd25: w = mk(OP_SUB,  R_P,   R_S1,  R_S2,   J_NEXT, '0);
            7'd26: w = mk(OP_SUB,  R_Q,   R_Q,   R_R,    J_NEXT, '0);
            7'd27: w = mk(OP_ADD,  R_Q,   R_Q,   R_Q,    J_NEXT, '0);
            7'd28: w = mk(OP_LT,   R_S1,  S_ZERO, R_Q,   J_NEXT, '0);
            7'd29: w = mk(OP_NEG,  R_S1,  R_P,   S_ZERO, J_NEXT, '0);
            7'd30: w = mk(OP_CSEL, R_P,   R_S1,  R_P,    J_NEXT, '0);
            7'd31: w = mk(OP_NEG,  R_S2,  R_Q,   S_ZERO, J_NEXT, '0);
            7'd32: w = mk(OP_CSEL, R_Q,   R_Q,   R_S2,   J_NEXT, '0);
            7'd33: w = mk(OP_MOV,  R_R,   R_E,   S_ZERO, J_NEXT, '0);
            7'd34: w = mk(OP_MOV,  R_E,   R_D,   S_ZERO, J_NEXT, '0);
            7'd35: w = mk(OP_ABS,  R_S1,  R_P,   S_ZERO, J_NEXT, '0);
            7'd36: w = mk(OP_MUL,  R_S2,  R_Q,   R_R,    J_NEXT, '0);
            7'd37: w = mk(OP_HALF, R_S2,  R_S2,  S_ZERO, J_NEXT, '0);
            7'd38: w = mk(OP_ABS,  R_S2,  R_S2,  S_ZERO, J_NEXT, '0);
            7'd39: w = mk(OP_LT,   R_S1,  R_S1,  R_S2,   J_IFN, UA_GOLDEN);
            7'd40: w = mk(OP_SUB,  R_S1,  S_LO,  S_X,    J_NEXT, '0);
            7'd41: w = mk(OP_MUL,  R_S1,  R_Q,   R_S1,   J_NEXT, '0);
            7'd42: w = mk(OP_LT,   R_S1,  R_P,   R_S1,   J_IFN, UA_GOLDEN);
            7'd43: w = mk(OP_SUB,  R_S1,  S_HI,  S_X,    J_NEXT, '0);
            7'd44: w = mk(OP_MUL,  R_S1,  R_Q,   R_S1,   J_NEXT, '0);
            7'd45: w = mk(OP_LT,   R_S1,  R_P,   R_S1,   J_IFN, UA_GOLDEN);
            7'd46: w = mk(OP_DIV,  R_D,   R_P,   R_Q,    J_NEXT, '0);
            7'd47: w = mk(OP_SAT,  R_D,   R_D,   S_ZERO, J_NEXT, '0);
            7'd48: w = mk(OP_ADD,  R_U,   S_X,   R_D,    J_NEXT, '0);
            7'd49: w = mk(OP_SUB,  R_S1,  R_U,   S_LO,   J_NEXT, '0);
            7'd50: w = mk(OP_LT,   R_S1,  R_S1,  R_T2,   J_IF, UA_FIXTOL);
            7'd51: w = mk(OP_SUB,  R_S1,  S_HI,  R_U,    J_NEXT, '0);
            7'd52: w = mk(OP_LT,   R_S1,  R_S1,  R_T2,   J_IFN, UA_FINAL);
            7'd53: w = mk(OP_LT,   R_S1,  S_X,   R_M,    J_NEXT, '0);
            7'd54: w = mk(OP_NEG,  R_S1,  R_TOL, S_ZERO, J_NEXT, '0);
            7'd55: w = mk(OP_CSEL, R_D,   R_TOL, R_S1,   J_GOTO, UA_FINAL);
            7'd56: w = mk(OP_LT,   R_S1,  S_X,   R_M,    J_NEXT, '0);
            7'd57: w = mk(OP_CSEL, R_S1,  S_HI,  S_LO,   J_NEXT, '0);
            7'd58: w = mk(OP_SUB,  R_S1,  R_S1,  S_X,    J_NEXT, '0);
            7'd59: w = mk(OP_SAT,  R_E,   R_S1,  S_ZERO, J_NEXT, '0);
            7'd60: w = mk(OP_MUL,  R_D,   S_GOLD, R_E,   J_NEXT, '0);
            7'd61: w = mk(OP_SAT,  R_D,   R_D,   S_ZERO, J_NEXT, '0);
            7'd62: w = mk(OP_ABS,  R_S1,  R_D,   S_ZERO, J_NEXT, '0);
            7'd63: w = mk(OP_LT,   R_S1,  R_S1,  R_TOL,  J_IFN, UA_USED);
            7'd64: w = mk(OP_LT,   R_S1,  S_ZERO, R_D,   J_NEXT, '0);
            7'd65: w = mk(OP_NEG,  R_S2,  R_TOL, S_ZERO, J_NEXT, '0);
            7'd66: w = mk(OP_CSEL, R_S1,  R_TOL, R_S2,   J_NEXT, '0);
            7'd67: w = mk(OP_ADD,  R_U,   S_X,   R_S1,   J_GOTO, UA_COMMIT);
            7'd68: w = mk(OP_ADD,  R_U,   S_X,   R_D,    J_NEXT, '0);
            7'd69: w = mk(OP_COMMIT, R_S1, S_ZERO, S_ZERO, J_REQ, '0);
            default: w = mk(OP_NOP, R_S1, S_ZERO, S_ZERO, J_NEXT, '0);
        endcase
        return w;
    endfunction

    function automatic logic [WIDE_W-1:0] sadd64(logic [WIDE_W-1:0] a, logic [WIDE_W-1:0] b);
        logic [WIDE_W:0] s;
        s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
        if (s[WIDE_W] != s[WIDE_W-1])
            return s[WIDE_W] ? MIN64 : MAX64;
        return s[WIDE_W-1:0];
    endfunction

    function automatic logic [WIDE_W-1:0] sneg64(logic [WIDE_W-1:0] a);
        return (a == MIN64) ? MAX64 : (~a + 64'd1);
    endfunction

    function automatic logic [WIDE_W-1:0] sabs64(logic [WIDE_W-1:0] a);
        return a[WIDE_W-1] ? sneg64(a) : a;
    endfunction

    function automatic logic [WIDE_W-1:0] half64(logic [WIDE_W-1:0] a);
        logic [WIDE_W-1:0] t;
        t = a + {{(WIDE_W-1){1'b0}}, a[WIDE_W-1]};
        return {t[WIDE_W-1], t[WIDE_W-1:1]};
    endfunction

    function automatic logic [WIDE_W-1:0] sat48w(logic [WIDE_W-1:0] a);
        if (a[WIDE_W-1] && (a[WIDE_W-2:VAL_W-1] != '1))
            return {{(WIDE_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}};
        if (!a[WIDE_W-1] && (a[WIDE_W-2:VAL_W-1] != '0))
            return {{(WIDE_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}};
        return a;
    endfunction

    function automatic logic [WIDE_W-1:0] mag64(logic [WIDE_W-1:0] a);
        return a[WIDE_W-1] ? (~a + 64'd1) : a;
    endfunction

endpackage

/* rtl/core/bsm_dp.sv */
// Datapath: search state, temporaries, saturating ALU, multiply and divide units.
module bsm_dp
    import bsm_pkg::*;
#(
    parameter int MAX_ITER  = 100,
    parameter int FRAC_BITS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  dp_cmd_t                  cmd,
    input  logic signed [VAL_W-1:0]  operand,
    input  logic signed [VAL_W-1:0]  cfg_left,
    input  logic signed [VAL_W-1:0]  cfg_right,
    input  logic [REL_W-1:0]         cfg_rel,
    output dp_stat_t                 stat,
    output logic signed [VAL_W-1:0]  pending_point,
    output logic signed [VAL_W-1:0]  best_point,
    output logic signed [VAL_W-1:0]  best_fval,
    output logic [ITER_W-1:0]        iter_count
);

    localparam logic [WIDE_W-1:0] GOLD = WIDE_W'(GOLD_Q40 >> (40 - FRAC_BITS));
    localparam int QW  = WIDE_W + FRAC_BITS;
    localparam int DCW = $clog2(QW);

    logic signed [VAL_W-1:0] lo_reg, hi_reg, x_reg, w_reg, v_reg;
    logic signed [VAL_W-1:0] fx_reg, fw_reg, fv_reg, step_reg, prev_reg, pend_reg;
    logic [ITER_W-1:0] iter_reg;
    logic [WIDE_W-1:0] tmp_reg [NUM_TMP];
    logic flag_reg;

    // multiply unit
    logic [WIDE_W-1:0] ma_reg, mb_reg;
    logic [127:0]      acc_reg;
    logic [1:0]        mcnt_reg;
    logic              mbusy_reg, mtol_reg, mneg_reg;
    // divide unit
    logic [QW-1:0]     num_reg, quo_reg;
    logic [WIDE_W:0]   rem_reg;
    logic [WIDE_W-1:0] dq_reg;
    logic [DCW-1:0]    dcnt_reg;
    logic              dbusy_reg, dneg_reg, dzero_reg;
    logic [3:0]        udst_reg;

    logic [WIDE_W-1:0] opa, opb, alu;
    logic              alu_wr, lt_now;
    logic [63:0]       pp;
    logic [127:0]      acc_sum, pp_sh;
    logic [WIDE_W-1:0] mres, mr, dres;
    logic [WIDE_W:0]   rem_sh;
    logic              ge;
    logic [QW-1:0]     quo_n;
    logic signed [VAL_W-1:0] v_in;
    logic [WIDE_W-1:0] e_sat, u_sat;

    function automatic logic [WIDE_W-1:0] pick(src_t s, logic [WIDE_W-1:0] t [NUM_TMP],
        logic signed [VAL_W-1:0] lo, logic signed [VAL_W-1:0] hi,
        logic signed [VAL_W-1:0] x, logic signed [VAL_W-1:0] w,
        logic signed [VAL_W-1:0] v, logic signed [VAL_W-1:0] fx,
        logic signed [VAL_W-1:0] fw, logic signed [VAL_W-1:0] fv,
        logic signed [VAL_W-1:0] st, logic signed [VAL_W-1:0] pv);
        logic [WIDE_W-1:0] r;
        case (s)
            S_ZERO: r = '0;
            S_LO:   r = WIDE_W'(lo);
            S_HI:   r = WIDE_W'(hi);
            S_X:    r = WIDE_W'(x);
            S_W:    r = WIDE_W'(w);
            S_V:    r = WIDE_W'(v);
            S_FX:   r = WIDE_W'(fx);
            S_FW:   r = WIDE_W'(fw);
            S_FV:   r = WIDE_W'(fv);
            S_STEP: r = WIDE_W'(st);
            S_PREV: r = WIDE_W'(pv);
            S_GOLD: r = GOLD;
            default: r = t[s[3:0]];
        endcase
        return r;
    endfunction

    assign v_in = operand;

    // committed previous step and point saturate to 48 bits
    assign e_sat = sat48w(tmp_reg[4'(R_E)]);
    assign u_sat = sat48w(tmp_reg[4'(R_U)]);

    always_comb
    begin
        opa = pick(cmd.sa, tmp_reg, lo_reg, hi_reg, x_reg, w_reg, v_reg, fx_reg, fw_reg,
                   fv_reg, step_reg, prev_reg);
        opb = pick(cmd.sb, tmp_reg, lo_reg, hi_reg, x_reg, w_reg, v_reg, fx_reg, fw_reg,
                   fv_reg, step_reg, prev_reg);
        lt_now = $signed(opa) < $signed(opb);
        alu_wr = 1'b1;
        case (cmd.op)
            OP_MOV:  alu = opa;
            OP_ADD:  alu = sadd64(opa, opb);
            OP_SUB:  alu = sadd64(opa, sneg64(opb));
            OP_NEG:  alu = sneg64(opa);
            OP_ABS:  alu = sabs64(opa);
            OP_HALF: alu = half64(opa);
            OP_SAT:  alu = sat48w(opa);
            OP_CSEL: alu = flag_reg ? opa : opb;
            default:
            begin
                alu = opa;
                alu_wr = 1'b0;
            end
        endcase
    end

    // one 32x32 partial product per cycle
    always_comb
    begin
        case (mcnt_reg)
            2'd0: pp = ma_reg[31:0] * mb_reg[31:0];
            2'd1: pp = ma_reg[31:0] * mb_reg[63:32];
            2'd2: pp = ma_reg[63:32] * mb_reg[31:0];
            default: pp = ma_reg[63:32] * mb_reg[63:32];
        endcase
        case (mcnt_reg)
            2'd0:    pp_sh = {64'd0, pp};
            2'd3:    pp_sh = {pp, 64'd0};
            default: pp_sh = {32'd0, pp, 32'd0};
        endcase
        acc_sum = acc_reg + pp_sh;
        mr = acc_sum[WIDE_W+FRAC_BITS-1:FRAC_BITS];
        if (mtol_reg)
            mres = acc_sum[95:32] + 64'd1;
        else if ((acc_sum[127:WIDE_W+FRAC_BITS] != '0) || mr[WIDE_W-1])
            mres = mneg_reg ? MIN64 : MAX64;
        else
            mres = mneg_reg ? (~mr + 64'd1) : mr;
    end

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh = {rem_reg[WIDE_W-1:0], num_reg[QW-1]};
        ge = rem_sh >= {1'b0, dq_reg};
        quo_n = {quo_reg[QW-2:0], ge};
        if (dzero_reg)
            dres = '0;
        else if (quo_n[QW-1:WIDE_W-1] != '0)
            dres = dneg_reg ? MIN64 : MAX64;
        else
            dres = dneg_reg ? (~quo_n[WIDE_W-1:0] + 64'd1) : quo_n[WIDE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lo_reg <= '0; hi_reg <= '0; x_reg <= '0; w_reg <= '0; v_reg <= '0;
            fx_reg <= '0; fw_reg <= '0; fv_reg <= '0;
            step_reg <= '0; prev_reg <= '0; pend_reg <= '0;
            iter_reg <= '0;
            flag_reg <= 1'b0;
            mbusy_reg <= 1'b0;
            dbusy_reg <= 1'b0;
            mcnt_reg <= '0;
            dcnt_reg <= '0;
        end
        else
        begin
            if (cmd.exec)
            begin
                if (cmd.op == OP_LT)
                    flag_reg <= lt_now;
                if (alu_wr)
                    tmp_reg[cmd.dst[3:0]] <= alu;
                case (cmd.op)
                    OP_MUL, OP_TOL:
                    begin
                        ma_reg <= mag64(opa);
                        mb_reg <= (cmd.op == OP_TOL) ? WIDE_W'(cfg_rel) : mag64(opb);
                        mneg_reg <= opa[WIDE_W-1] ^ opb[WIDE_W-1];
                        mtol_reg <= (cmd.op == OP_TOL);
                        acc_reg <= '0;
                        mcnt_reg <= '0;
                        mbusy_reg <= 1'b1;
                        udst_reg <= cmd.dst[3:0];
                    end
                    OP_DIV:
                    begin
                        num_reg <= {mag64(opa), {FRAC_BITS{1'b0}}};
                        dq_reg <= mag64(opb);
                        dzero_reg <= (opb == '0);
                        dneg_reg <= opa[WIDE_W-1] ^ opb[WIDE_W-1];
                        rem_reg <= '0;
                        quo_reg <= '0;
                        dcnt_reg <= '0;
                        dbusy_reg <= 1'b1;
                        udst_reg <= cmd.dst[3:0];
                    end
                    OP_COMMIT:
                    begin
                        step_reg <= tmp_reg[4'(R_D)][VAL_W-1:0];
                        prev_reg <= e_sat[VAL_W-1:0];
                        pend_reg <= u_sat[VAL_W-1:0];
                    end
                    OP_START:
                    begin
                        lo_reg <= cfg_left;
                        hi_reg <= cfg_right;
                        x_reg <= v_in; w_reg <= v_in; v_reg <= v_in;
                        step_reg <= '0; prev_reg <= '0;
                        iter_reg <= '0;
                        pend_reg <= v_in;
                    end
                    OP_LOADF:
                    begin
                        fx_reg <= v_in; fw_reg <= v_in; fv_reg <= v_in;
                    end
                    OP_UPDATE:
                    begin
                        if (v_in <= fx_reg)
                        begin
                            if (pend_reg < x_reg) hi_reg <= x_reg;
                            else lo_reg <= x_reg;
                            v_reg <= w_reg; fv_reg <= fw_reg;
                            w_reg <= x_reg; fw_reg <= fx_reg;
                            x_reg <= pend_reg; fx_reg <= v_in;
                        end
                        else
                        begin
                            if (pend_reg < x_reg) lo_reg <= pend_reg;
                            else hi_reg <= pend_reg;
                            if (v_in <= fw_reg || w_reg == x_reg)
                            begin
                                v_reg <= w_reg; fv_reg <= fw_reg;
                                w_reg <= pend_reg; fw_reg <= v_in;
                            end
                            else if (v_in <= fv_reg || v_reg == x_reg || v_reg == w_reg)
                            begin
                                v_reg <= pend_reg; fv_reg <= v_in;
                            end
                        end
                        iter_reg <= iter_reg + 1'b1;
                    end
                    default: ;
                endcase
            end
            if (mbusy_reg)
            begin
                acc_reg <= acc_sum;
                mcnt_reg <= mcnt_reg + 1'b1;
                if (mcnt_reg == 2'd3)
                begin
                    mbusy_reg <= 1'b0;
                    tmp_reg[udst_reg] <= mres;
                end
            end
            if (dbusy_reg)
            begin
                rem_reg <= ge ? (rem_sh - {1'b0, dq_reg}) : rem_sh;
                quo_reg <= quo_n;
                num_reg <= {num_reg[QW-2:0], 1'b0};
                dcnt_reg <= dcnt_reg + 1'b1;
                if (dcnt_reg == DCW'(QW - 1))
                begin
                    dbusy_reg <= 1'b0;
                    tmp_reg[udst_reg] <= dres;
                end
            end
        end
    end

    assign stat.lt = lt_now;
    assign stat.unit_done = (mbusy_reg && mcnt_reg == 2'd3) ||
                            (dbusy_reg && dcnt_reg == DCW'(QW - 1));
    assign stat.iter_done = iter_reg >= ITER_W'(MAX_ITER);

    assign pending_point = pend_reg;
    assign best_point    = x_reg;
    assign best_fval     = fx_reg;
    assign iter_count    = iter_reg;

endmodule

/* rtl/core/bsm_ctrl.sv */
// Controller: phase tracking and microcode sequencer for one Brent step.
module bsm_ctrl
    import bsm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_opcode,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    input  logic     out_free,
    output logic     emit,
    output kind_t    kind
);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    kind_t  kind_reg, kind_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    uc_t    w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_IDLE;
            kind_reg  <= K_REQ;
            pc_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            kind_reg  <= kind_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        w = uc_rom(pc_reg);
        state_next = state_reg;
        phase_next = phase_reg;
        kind_next  = kind_reg;
        pc_next    = pc_reg;
        in_ready   = 1'b0;
        emit       = 1'b0;
        cmd.exec   = 1'b0;
        cmd.op     = w.op;
        cmd.dst    = w.dst;
        cmd.sa     = w.sa;
        cmd.sb     = w.sb;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                pc_next = '0;
                if (in_valid)
                begin
                    if (!in_opcode)
                    begin
                        cmd.exec = 1'b1;
                        cmd.op = OP_START;
                        phase_next = PH_F0;
                        kind_next = K_REQ;
                        state_next = ST_EMIT;
                    end
                    else if (phase_reg == PH_F0)
                    begin
                        cmd.exec = 1'b1;
                        cmd.op = OP_LOADF;
                        state_next = ST_RUN;
                    end
                    else if (phase_reg == PH_FU)
                    begin
                        cmd.exec = 1'b1;
                        cmd.op = OP_UPDATE;
                        state_next = ST_RUN;
                    end
                    else
                    begin
                        kind_next = K_REJ;
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_RUN:
            begin
                cmd.exec = 1'b1;
                if (w.op == OP_MUL || w.op == OP_TOL || w.op == OP_DIV)
                    state_next = ST_WAIT;
                else
                begin
                    pc_next = pc_reg + 1'b1;
                    unique case (w.jmp)
                        J_IF:   if (stat.lt) pc_next = w.tgt;
                        J_IFN:  if (!stat.lt) pc_next = w.tgt;
                        J_GOTO: pc_next = w.tgt;
                        J_STOP:
                            if (!stat.lt || stat.iter_done)
                            begin
                                phase_next = PH_IDLE;
                                kind_next = K_DONE;
                                state_next = ST_EMIT;
                            end
                        J_REQ:
                        begin
                            phase_next = PH_FU;
                            kind_next = K_REQ;
                            state_next = ST_EMIT;
                        end
                        default: ;
                    endcase
                end
            end
            ST_WAIT:
            begin
                if (stat.unit_done)
                begin
                    pc_next = pc_reg + 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_EMIT:
            begin
                emit = 1'b1;
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign kind = kind_reg;

endmodule

/* rtl/core/brent_scalar_minimizer.sv */
// Top level: Brent one-variable minimizer step engine with stream ports.
//
// Channel  | Dir | Signals                         | Contents
// s_axis   | in  | tvalid/tready/tdata/tuser       | tuser: opcode; tdata: operand
// m_axis   | out | tvalid/tready/tdata/tuser       | tuser: kind; tdata: point, best_value,
//          |     |                                 |   iterations
// cfg      | in  | cfg_we/cfg_addr/cfg_wdata       | left_bound, right_bound, rel_accuracy
//
// From the accepting edge to the output register load: a start or reject transaction
// goes straight to the emit state, a function value that ends the search stops at the
// stop test, and a golden-section step (also when a parabolic fit is tried and refused)
// or a parabolic step runs on through the microcode, each product on the shared 32x32
// multiplier and p/q in the one-bit-per-cycle divider.
// One item is in work at a time; s_axis_tready is high only while the sequencer is
// idle. A full output register holds the sequencer in its emit state. Reset is
// asynchronous, active low.
module brent_scalar_minimizer
    import bsm_pkg::*;
#(
    parameter int MAX_ITER  = 100,
    parameter int FRAC_BITS = 32
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [47:0]         s_axis_tdata,   // [47:0] operand
    input  logic                s_axis_tuser,   // [0] opcode
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [111:0]        m_axis_tdata,   // [47:0] point, [95:48] best_value,
                                                // [105:96] iterations, rest zero
    output logic [1:0]          m_axis_tuser,   // [1:0] kind
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [VAL_W-1:0]    cfg_wdata
);

    localparam logic [1:0] CFG_LEFT  = 2'd0;
    localparam logic [1:0] CFG_RIGHT = 2'd1;
    localparam logic [1:0] CFG_REL   = 2'd2;

    logic signed [VAL_W-1:0] left_reg, right_reg;
    logic [REL_W-1:0]        rel_reg;

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     emit, out_free;
    kind_t    kind;
    logic signed [VAL_W-1:0] pend, xbest, fbest;
    logic [ITER_W-1:0]       iters;

    logic        out_valid_reg;
    logic [1:0]  out_kind_reg;
    logic [VAL_W-1:0] out_point_reg, out_fval_reg;
    logic [ITER_W-1:0] out_iter_reg;

    // configuration registers; an index past the list is ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            right_reg <= 48'sd4294967296;
            rel_reg   <= 32'd4295;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_LEFT:  left_reg  <= cfg_wdata;
                CFG_RIGHT: right_reg <= cfg_wdata;
                CFG_REL:   rel_reg   <= cfg_wdata[REL_W-1:0];
                default: ;
            endcase
        end
    end

    bsm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_opcode (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .stat      (stat),
        .cmd       (cmd),
        .out_free  (out_free),
        .emit      (emit),
        .kind      (kind)
    );

    bsm_dp #(
        .MAX_ITER  (MAX_ITER),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .operand       (s_axis_tdata),
        .cfg_left      (left_reg),
        .cfg_right     (right_reg),
        .cfg_rel       (rel_reg),
        .stat          (stat),
        .pending_point (pend),
        .best_point    (xbest),
        .best_fval     (fbest),
        .iter_count    (iters)
    );

    // output register decouples the sequencer from the sink
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit && out_free)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit && out_free)
        begin
            out_kind_reg  <= kind;
            out_point_reg <= (kind == K_REQ) ? pend : xbest;
            out_fval_reg  <= fbest;
            out_iter_reg  <= iters;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {6'd0, out_iter_reg, out_fval_reg, out_point_reg};

    // an accepted transaction always takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted twice in a row");

    // results are only requests, done or reject
    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == K_REQ || m_axis_tuser == K_DONE ||
                           m_axis_tuser == K_REJ))
        else $error("illegal result kind");

    // the multiply and divide units never report completion while idle
    a_unit_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.unit_done |-> !s_axis_tready)
        else $error("arithmetic unit finished while idle");

endmodule
